### rtl/core/image_rotate_nearest_defines.svh
// ----------------------------------------------------------------------------
// Image rotate assertion macros
// Shared concurrent assertion forms, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_NEAREST_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_DEFINES_SVH

// Check a property outside of reset.
`define IRN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define IRN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/irn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate package
// Field widths, register codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int unsigned SIDE_W      = 10;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned CTR_W       = 9;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned TRIG_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam int unsigned MAX_SIDE_DEF  = 512;
  localparam int unsigned FRAC_BITS_DEF = 14;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [SIDE_W-1:0]        HEIGHT_RST = 10'd512;
  localparam logic [SIDE_W-1:0]        WIDTH_RST  = 10'd512;
  localparam logic signed [TRIG_W-1:0] COS_RST    = 16'sd11585;
  localparam logic signed [TRIG_W-1:0] SIN_RST    = 16'sd11585;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT,
    REG_WIDTH,
    REG_COS,
    REG_SIN
  } reg_idx_e;

  // Class of a queued item: store write, in-frame query, query off the frame.
  typedef enum logic [1:0] {
    CLS_LOAD,
    CLS_QUERY,
    CLS_OFF
  } cls_e;

  typedef struct packed {
    cls_e               cls;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [PIX_W-1:0]   pixel;
    logic [SIDE_W-1:0]  width;
  } item_t;

  typedef struct packed {
    logic [SIDE_W-1:0]        h;
    logic [SIDE_W-1:0]        w;
    logic [CTR_W-1:0]         ch;
    logic [CTR_W-1:0]         cw;
    logic signed [TRIG_W-1:0] cos_q14;
    logic signed [TRIG_W-1:0] sin_q14;
  } geom_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

endpackage

### rtl/core/irn_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface irn_in_if;
  import irn_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [PIX_W-1:0] pixel_in;
  modport source(output valid, kind, row, col, pixel_in, input ready);
  modport sink(input valid, kind, row, col, pixel_in, output ready);
endinterface

interface irn_out_if;
  import irn_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             outside;
  modport source(output valid, pixel_out, outside, input ready);
  modport sink(input valid, pixel_out, outside, output ready);
endinterface

interface irn_cfg_if;
  import irn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/irn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate front end
// Holds configuration, clamps the frame size and classifies input items.
// ----------------------------------------------------------------------------
module irn_front #(
  parameter int unsigned MAX_SIDE = irn_pkg::MAX_SIDE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  irn_in_if.sink        in_i,
  irn_cfg_if.sink       cfg_i,
  input  logic          q_ready_i,
  output irn_pkg::q_wr_t q_wr_o,
  output irn_pkg::geom_t geom_o
);
  import irn_pkg::*;

  logic [SIDE_W-1:0]        height_q;
  logic [SIDE_W-1:0]        width_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  logic [SIDE_W-1:0]        h;
  logic [SIDE_W-1:0]        w;
  logic                     in_frame;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RST;
      width_q  <= WIDTH_RST;
      cos_q    <= COS_RST;
      sin_q    <= SIN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_HEIGHT: height_q <= cfg_i.data[SIDE_W-1:0];
        REG_WIDTH:  width_q  <= cfg_i.data[SIDE_W-1:0];
        REG_COS:    cos_q    <= $signed(cfg_i.data[TRIG_W-1:0]);
        REG_SIN:    sin_q    <= $signed(cfg_i.data[TRIG_W-1:0]);
      endcase
    end
  end

  assign h = clamp_side(height_q);
  assign w = clamp_side(width_q);

  assign geom_o.h       = h;
  assign geom_o.w       = w;
  assign geom_o.ch      = CTR_W'(h >> 1);
  assign geom_o.cw      = CTR_W'(w >> 1);
  assign geom_o.cos_q14 = cos_q;
  assign geom_o.sin_q14 = sin_q;

  assign in_frame = (SIDE_W'(in_i.row) < h) && (SIDE_W'(in_i.col) < w);
  assign in_i.ready = q_ready_i;

  // Drop loads off the frame; queries off the frame still owe a result.
  always_comb begin
    q_wr_o.item.row   = in_i.row;
    q_wr_o.item.col   = in_i.col;
    q_wr_o.item.pixel = in_i.pixel_in;
    q_wr_o.item.width = w;
    if (in_i.kind == KIND_QUERY) begin
      q_wr_o.push     = in_i.valid && q_ready_i;
      q_wr_o.item.cls = in_frame ? CLS_QUERY : CLS_OFF;
    end else begin
      q_wr_o.push     = in_i.valid && q_ready_i && in_frame;
      q_wr_o.item.cls = CLS_LOAD;
    end
  end

endmodule

### rtl/core/irn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate item queue
// Short FIFO that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module irn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irn_pkg::q_wr_t q_wr_i,
  output logic           ready_o,
  output irn_pkg::q_rd_t q_rd_o,
  input  logic           pop_i
);
  import irn_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign ready_o      = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_rd_o.valid = (count_q != '0);
  assign q_rd_o.item  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      entry_q[wr_ptr_q] <= q_wr_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (q_wr_i.push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (q_wr_i.push && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !q_wr_i.push) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

### rtl/core/irn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate back end
// Five-stage pipeline: products, sums, truncate and bound, address, store.
// ----------------------------------------------------------------------------
module irn_back #(
  parameter int unsigned MAX_SIDE  = irn_pkg::MAX_SIDE_DEF,
  parameter int unsigned FRAC_BITS = irn_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irn_pkg::geom_t geom_i,
  input  irn_pkg::q_rd_t q_rd_i,
  output logic           pop_o,
  irn_out_if.source      out_o
);
  import irn_pkg::*;

  localparam int unsigned DR_W        = SIDE_W + 1;
  localparam int unsigned PROD_W      = DR_W + TRIG_W;
  localparam int unsigned SUM_W       =
    ((PROD_W > SIDE_W + FRAC_BITS) ? PROD_W : SIDE_W + FRAC_BITS) + 2;
  localparam int unsigned EXT_W       = SUM_W - PROD_W;
  localparam int unsigned QW          = SUM_W - FRAC_BITS;
  localparam int unsigned STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned LIN_W       = 2 * SIDE_W + 1;

  logic adv;

  // stage 1
  logic                     v1_q;
  item_t                    it1_q;
  logic signed [DR_W-1:0]   dr;
  logic signed [DR_W-1:0]   dc;
  logic signed [PROD_W-1:0] p_rc_d, p_cs_d, p_rs_d, p_cc_d;
  logic signed [PROD_W-1:0] p_rc_q, p_cs_q, p_rs_q, p_cc_q;

  // stage 2
  logic                    v2_q;
  item_t                   it2_q;
  logic signed [SUM_W-1:0] e_rc, e_cs, e_rs, e_cc, ch_sh, cw_sh;
  logic signed [SUM_W-1:0] sum_r_d, sum_c_d;
  logic signed [SUM_W-1:0] sum_r_q, sum_c_q;

  // stage 3
  logic [SUM_W-1:0]  adj_r, adj_c;
  logic [QW-1:0]     q_r, q_c;
  logic              off_r, off_c;
  logic              v3_q;
  cls_e              cls3_q;
  logic [PIX_W-1:0]  pix3_q;
  logic [SIDE_W-1:0] lw3_q;
  logic [SIDE_W-1:0] sr3_d, sc3_d, sr3_q, sc3_q;
  logic              off3_d, off3_q;

  // stage 4
  logic [LIN_W-1:0] lin;
  logic             v4_q;
  cls_e             cls4_q;
  logic [PIX_W-1:0] pix4_q;
  logic [AW-1:0]    addr4_q;
  logic             off4_q;

  // stage 5
  logic [PIX_W-1:0] store [STORE_DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic             out_valid_q;
  logic             outside_q;

  // Hold the whole pipeline while a result waits at the output.
  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && q_rd_i.valid;

  assign dr = $signed({{(DR_W - POS_W){1'b0}}, q_rd_i.item.row})
            - $signed({{(DR_W - CTR_W){1'b0}}, geom_i.ch});
  assign dc = $signed({{(DR_W - POS_W){1'b0}}, q_rd_i.item.col})
            - $signed({{(DR_W - CTR_W){1'b0}}, geom_i.cw});

  assign p_rc_d = dr * geom_i.cos_q14;
  assign p_cs_d = dc * geom_i.sin_q14;
  assign p_rs_d = dr * geom_i.sin_q14;
  assign p_cc_d = dc * geom_i.cos_q14;

  assign e_rc  = {{EXT_W{p_rc_q[PROD_W-1]}}, p_rc_q};
  assign e_cs  = {{EXT_W{p_cs_q[PROD_W-1]}}, p_cs_q};
  assign e_rs  = {{EXT_W{p_rs_q[PROD_W-1]}}, p_rs_q};
  assign e_cc  = {{EXT_W{p_cc_q[PROD_W-1]}}, p_cc_q};
  assign ch_sh = {{(SUM_W - CTR_W - FRAC_BITS){1'b0}}, geom_i.ch, {FRAC_BITS{1'b0}}};
  assign cw_sh = {{(SUM_W - CTR_W - FRAC_BITS){1'b0}}, geom_i.cw, {FRAC_BITS{1'b0}}};

  assign sum_r_d = e_rc - e_cs + ch_sh;
  assign sum_c_d = e_rs + e_cc + cw_sh;

  // Bias negative sums so the shift rounds toward zero.
  assign adj_r = sum_r_q + {{(SUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{sum_r_q[SUM_W-1]}}};
  assign adj_c = sum_c_q + {{(SUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{sum_c_q[SUM_W-1]}}};
  assign q_r   = adj_r[SUM_W-1:FRAC_BITS];
  assign q_c   = adj_c[SUM_W-1:FRAC_BITS];
  assign off_r = q_r[QW-1] || (q_r >= {{(QW - SIDE_W){1'b0}}, geom_i.h});
  assign off_c = q_c[QW-1] || (q_c >= {{(QW - SIDE_W){1'b0}}, geom_i.w});

  always_comb begin
    unique case (it2_q.cls)
      CLS_LOAD: begin
        sr3_d  = {{(SIDE_W - POS_W){1'b0}}, it2_q.row};
        sc3_d  = {{(SIDE_W - POS_W){1'b0}}, it2_q.col};
        off3_d = 1'b0;
      end
      CLS_QUERY: begin
        sr3_d  = q_r[SIDE_W-1:0];
        sc3_d  = q_c[SIDE_W-1:0];
        off3_d = off_r || off_c;
      end
      default: begin
        sr3_d  = '0;
        sc3_d  = '0;
        off3_d = 1'b1;
      end
    endcase
  end

  assign lin = LIN_W'(sr3_q) * LIN_W'(lw3_q) + LIN_W'(sc3_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q   <= q_rd_i.item;
      p_rc_q  <= p_rc_d;
      p_cs_q  <= p_cs_d;
      p_rs_q  <= p_rs_d;
      p_cc_q  <= p_cc_d;
      it2_q   <= it1_q;
      sum_r_q <= sum_r_d;
      sum_c_q <= sum_c_d;
      cls3_q  <= it2_q.cls;
      pix3_q  <= it2_q.pixel;
      lw3_q   <= it2_q.width;
      sr3_q   <= sr3_d;
      sc3_q   <= sc3_d;
      off3_q  <= off3_d;
      cls4_q  <= cls3_q;
      pix4_q  <= pix3_q;
      addr4_q <= AW'(lin);
      off4_q  <= off3_q;
      outside_q <= off4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v4_q) begin
      if (cls4_q == CLS_LOAD) begin
        store[addr4_q] <= pix4_q;
      end else if (!off4_q) begin
        rd_q <= store[addr4_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= q_rd_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q && (cls4_q != CLS_LOAD);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.outside   = outside_q;
  assign out_o.pixel_out = outside_q ? '0 : rd_q;

endmodule

### rtl/core/image_rotate_nearest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate, nearest neighbor
// Rotates a grey frame about its center by inverse mapping into a frame store.
// ----------------------------------------------------------------------------
// Load items write one pixel into the MAX_SIDE x MAX_SIDE byte frame store at
// row * width + col (loads off the frame are dropped, loads give no result);
// query items return one result each, the source pixel found through the
// Q2.14 cosine and sine registers, or 0 with outside set. One item is taken
// per clock while the queue has room: the front end classifies it into a
// four-entry queue and a five-stage back-end pipeline (products, sums,
// truncate and bound, address multiply, store access) retires one item per
// clock while results are taken. When the result is not taken the pipeline
// holds and the queue fills its four entries before input ready drops. The
// store is not cleared after reset; read only pixels already loaded. Write
// configuration only while no item is in flight.
module image_rotate_nearest #(
  parameter int unsigned MAX_SIDE  = irn_pkg::MAX_SIDE_DEF,
  parameter int unsigned FRAC_BITS = irn_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  irn_in_if.sink     in_i,
  irn_out_if.source  out_o,
  irn_cfg_if.sink    cfg_i
);
  import irn_pkg::*;
  `include "image_rotate_nearest_defines.svh"

  q_wr_t q_wr;
  q_rd_t q_rd;
  geom_t geom;
  logic  q_ready;
  logic  q_pop;

  irn_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .q_wr_o    (q_wr),
    .geom_o    (geom)
  );

  irn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .ready_o (q_ready),
    .q_rd_o  (q_rd),
    .pop_i   (q_pop)
  );

  irn_back #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geom_i (geom),
    .q_rd_i (q_rd),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

  `IRN_ASSERT(a_push_has_room, q_wr.push |-> q_ready, "queue push while full")
  `IRN_ASSERT(a_pop_has_item, q_pop |-> q_rd.valid, "queue pop while empty")
  `IRN_ASSERT(a_full_needs_stall, !q_ready |-> $past(!q_pop), "queue filled despite a pop")
  `IRN_ASSERT_ALWAYS(a_quiet_out_of_reset, !rst_ni |=> !out_o.valid, "result right after reset")

endmodule
